### sv/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/uhr_pkg.sv
`default_nettype none

package uhr_pkg;

   localparam int HOLD_DEPTH = 19;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int HW_W       = 4;
   localparam int SUM_W      = 21;
   localparam int PART_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [HW_W-1:0]  HW_MIN   = 4'd5;
   localparam logic [15:0]      ONES_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DST_MAC     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_IP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_IP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PORT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_PORT = 3'd4;

   // position of a word after the header
   typedef enum logic [1:0] {
      PASS_PORT,
      PASS_CSUM,
      PASS_BODY
   } pass_type;

   typedef struct packed {
      logic [31:0] frame_word;
      logic [2:0]  bytes_valid;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [2:0]  out_bytes_valid;
      logic        out_end;
   } rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nv;
      logic        last;
      logic        csum_slot;
   } cell_type;

   typedef struct packed {
      logic [47:0] dst_mac;
      logic [31:0] dest_ip;
      logic [31:0] source_ip;
      logic [15:0] dst_port;
      logic [15:0] source_port;
   } cfg_type;

   typedef struct packed {
      logic             header_done;
      pass_type         pass;
      logic [CNT_W-1:0] k;
      logic [HW_W-1:0]  hw;
   } patch_ctx_type;

   typedef struct packed {
      cell_type          slot;
      logic [PART_W-1:0] contrib;
      logic [HW_W-1:0]   hw_new;
   } patch_res_type;

   function automatic logic [31:0] byte_mask(input logic [2:0] nv);
      logic [31:0] m;
      case (nv)
         3'd1:    m = 32'hFF00_0000;
         3'd2:    m = 32'hFFFF_0000;
         3'd3:    m = 32'hFFFF_FF00;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [15:0] fold_csum(input logic [SUM_W-1:0] s);
      logic [16:0] s1;
      logic [15:0] s2;
      s1 = {12'h000, s[SUM_W-1:16]} + {1'b0, s[15:0]};
      s2 = s1[15:0] + {15'h0000, s1[16]};
      return ~s2 & ONES_MAX;
   endfunction

endpackage

`default_nettype wire

### sv/uhr_cell.sv
`default_nettype none

module uhr_cell
   import uhr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     shift_en,
   input  wire logic     load_en,
   input  wire cell_type load_data,
   input  wire cell_type next_data,
   output cell_type      data_out
);

   cell_type data_ff;
   cell_type data_in;

   // a load wins over the shift from the neighbour
   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

### sv/uhr_patch.sv
`default_nettype none

module uhr_patch
   import uhr_pkg::*;
(
   input  wire req_type       req,
   input  wire patch_ctx_type ctx,
   input  wire cfg_type       cfg,
   output patch_res_type      res
);

   logic [2:0]       nv;
   logic [31:0]      vmask;
   logic [31:0]      w;
   logic [CNT_W-1:0] k_port;
   logic [CNT_W-1:0] k_full_hi;
   logic             body_word;
   logic             use_hi;
   logic             use_lo;
   logic [3:0]       ihl;

   always_comb begin
      nv = 3'd4;
      if (req.frame_end && req.bytes_valid >= 3'd1 && req.bytes_valid <= 3'd3) begin
         nv = req.bytes_valid;
      end
      vmask     = byte_mask(nv);
      k_port    = CNT_W'(3) + CNT_W'(ctx.hw);
      k_full_hi = CNT_W'(2) + CNT_W'(ctx.hw);

      w = req.frame_word & vmask;
      if (ctx.header_done) begin
         case (ctx.pass)
            PASS_PORT: w = {cfg.dst_port, w[15:0]};
            PASS_CSUM: w = {16'h0000, w[15:0]};
            default:   w = w;
         endcase
      end else begin
         if (ctx.k == CNT_W'(0)) begin
            w = cfg.dst_mac[47:16];
         end
         if (ctx.k == CNT_W'(1)) begin
            w = {cfg.dst_mac[15:0], w[15:0]};
         end
         // checksum bytes stay zero until the drain
         if (ctx.k == CNT_W'(6)) begin
            w = {16'h0000, cfg.source_ip[31:16]};
         end
         if (ctx.k == CNT_W'(7)) begin
            w = {cfg.source_ip[15:0], cfg.dest_ip[31:16]};
         end
         if (ctx.k == CNT_W'(8)) begin
            w = {cfg.dest_ip[15:0], w[15:0]};
         end
         if (ctx.k == k_port) begin
            w = {w[31:16], cfg.source_port};
         end
      end
      w = w & vmask;

      // header halfwords run from byte 14 up to the udp header
      body_word = (ctx.k >= CNT_W'(4)) && (ctx.k <= k_full_hi);
      use_hi    = body_word || (ctx.k == k_port);
      use_lo    = body_word || (ctx.k == CNT_W'(3));

      res.contrib = (use_hi ? {1'b0, w[31:16]} : PART_W'(0))
                  + (use_lo ? {1'b0, w[15:0]}  : PART_W'(0));

      ihl = (nv >= 3'd3) ? req.frame_word[11:8] : HW_MIN;
      res.hw_new = (ihl < HW_MIN) ? HW_MIN : ihl;

      res.slot.word      = w;
      res.slot.nv        = nv;
      res.slot.last      = req.frame_end;
      res.slot.csum_slot = !ctx.header_done && (ctx.k == CNT_W'(6));
   end

endmodule

`default_nettype wire

### sv/udp_header_rewrite.sv
// channel  | ports            | item
// ---------+------------------+-------------------------------------------
// request  | req_valid/stall  | frame word, bytes valid, frame end
// response | rsp_valid/stall  | rewritten word, bytes valid, frame end
// csr      | csr_write_en     | index and data, no read-back
//
// header words fill a row of cells one per cycle until the ipv4 header is
// complete: 9 to 19 words, set by the ihl nibble, or fewer when the frame ends
// the held words leave from the head cell one per cycle from the next cycle on
// unless the response stalls; the request is stalled until the last held word
// is taken; later words are registered in the head cell; a stalled response
// holds the row; reset is synchronous and clears control state and registers
`default_nettype none

module udp_header_rewrite
   import uhr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // frame control
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rel_ff;
   logic             rel_in;
   logic             hdone_ff;
   logic             hdone_in;
   logic [HW_W-1:0]  hw_ff;
   logic [HW_W-1:0]  hw_in;
   pass_type         pass_ff;
   pass_type         pass_in;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   logic             take;
   logic             in_ok;
   logic             in_acc;
   logic             release_now;
   logic [CNT_W-1:0] k;
   logic [15:0]      csum;

   patch_ctx_type ctx;
   patch_res_type pres;
   cell_type      cells [HOLD_DEPTH];

   // handshakes
   assign take      = rel_ff && !rsp_stall;
   assign in_ok     = !rel_ff || (take && count_ff == CNT_W'(1));
   assign req_stall = !in_ok;
   assign in_acc    = req_valid && in_ok;
   assign rsp_valid = rel_ff;

   // slot for the incoming word, one lower when the row moves this cycle
   assign k = count_ff - CNT_W'(take);

   assign release_now = in_acc && !hdone_ff
                     && (req_data.frame_end || k == CNT_W'(3) + CNT_W'(hw_ff));

   // word patching and checksum part
   always_comb begin
      ctx.header_done = hdone_ff;
      ctx.pass        = pass_ff;
      ctx.k           = k;
      ctx.hw          = hw_ff;
   end

   uhr_patch u_patch (
      .req (req_data),
      .ctx (ctx),
      .cfg (cfg_ff),
      .res (pres)
   );

   // row of cells, head at index 0
   for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
      cell_type nbr;
      if (i == HOLD_DEPTH - 1) begin : g_tail
         assign nbr = cells[i];
      end else begin : g_mid
         assign nbr = cells[i+1];
      end
      uhr_cell u_cell (
         .clock     (clock),
         .shift_en  (take),
         .load_en   (in_acc && k == CNT_W'(i)),
         .load_data (pres.slot),
         .next_data (nbr),
         .data_out  (cells[i])
      );
   end

   // header checksum goes into the word that carries bytes 24 and 25
   assign csum = fold_csum(sum_ff);

   always_comb begin
      rsp_data.out_word = cells[0].word;
      if (cells[0].csum_slot) begin
         rsp_data.out_word = cells[0].word | ({csum, 16'h0000} & byte_mask(cells[0].nv));
      end
      rsp_data.out_bytes_valid = cells[0].nv;
      rsp_data.out_end         = cells[0].last;
   end

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DST_MAC:     cfg_in.dst_mac     = csr_wdata;
            CSR_DEST_IP:     cfg_in.dest_ip     = csr_wdata[31:0];
            CSR_SOURCE_IP:   cfg_in.source_ip   = csr_wdata[31:0];
            CSR_DST_PORT:    cfg_in.dst_port    = csr_wdata[15:0];
            CSR_SOURCE_PORT: cfg_in.source_port = csr_wdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // row occupancy and release
   always_comb begin
      count_in = count_ff + CNT_W'(in_acc) - CNT_W'(take);
      rel_in   = rel_ff;
      if (in_acc) begin
         rel_in = hdone_ff || release_now;
      end else if (take && count_ff == CNT_W'(1)) begin
         rel_in = 1'b0;
      end
   end

   // frame state, back to its start after the last word of a frame
   always_comb begin
      hdone_in = hdone_ff;
      hw_in    = hw_ff;
      sum_in   = sum_ff;
      if (in_acc) begin
         if (!hdone_ff) begin
            sum_in = ((k == CNT_W'(0)) ? SUM_W'(0) : sum_ff) + SUM_W'(pres.contrib);
            if (k == CNT_W'(3)) begin
               hw_in = pres.hw_new;
            end
         end
         if (req_data.frame_end) begin
            hdone_in = 1'b0;
            hw_in    = HW_MIN;
         end else if (release_now) begin
            hdone_in = 1'b1;
         end
      end
   end

   // position after the header
   always_comb begin
      pass_in = pass_ff;
      if (in_acc) begin
         if (req_data.frame_end || release_now) begin
            pass_in = PASS_PORT;
         end else if (hdone_ff) begin
            case (pass_ff)
               PASS_PORT: pass_in = PASS_CSUM;
               PASS_CSUM: pass_in = PASS_BODY;
               default:   pass_in = PASS_BODY;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         count_ff <= '0;
         rel_ff   <= 1'b0;
         hdone_ff <= 1'b0;
         hw_ff    <= HW_MIN;
         pass_ff  <= PASS_PORT;
         sum_ff   <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         count_ff <= count_in;
         rel_ff   <= rel_in;
         hdone_ff <= hdone_in;
         hw_ff    <= hw_in;
         pass_ff  <= pass_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

`default_nettype wire

### sv/uhr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module uhr_checker
   import uhr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a response waiting on a stall stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // only the closing word of a frame may be short
   `ASSERT_IMPLY(a_short_only_last, clock, reset, rsp_valid && !rsp_data.out_end, rsp_data.out_bytes_valid == 3'd4)

   `ASSERT_IMPLY(a_bytes_range, clock, reset, rsp_valid, rsp_data.out_bytes_valid != 3'd0 && rsp_data.out_bytes_valid <= 3'd4)

   // nothing is offered straight after reset
   `ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clock, reset, !rsp_valid)

endmodule

bind udp_header_rewrite uhr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
